>>> rtl/core/cwdc_pkg.sv
// Shared types and constants for the centre-window dominant colour block.
package cwdc_pkg;

  localparam int CFG_W       = 13;
  localparam int COUNT_W     = 17;
  localparam int NUM_CLASSES = 8;
  localparam int CLASS_W     = 3;
  localparam int LEVEL_W     = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [0:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  // Lower hue bound of each band, and one past the top of the magenta band
  localparam logic [16:0] HUE_YELLOW_LO  = 17'd30;
  localparam logic [16:0] HUE_GREEN_LO   = 17'd91;
  localparam logic [16:0] HUE_CYAN_LO    = 17'd151;
  localparam logic [16:0] HUE_BLUE_LO    = 17'd211;
  localparam logic [16:0] HUE_MAGENTA_LO = 17'd271;
  localparam logic [16:0] HUE_BAND_END   = 17'd331;

  localparam logic [16:0] SAT_SCALE   = 17'd255;
  localparam logic [16:0] SAT_LIMIT   = 17'd128;
  localparam logic [7:0]  VALUE_LIMIT = 8'd128;

  typedef enum logic [CLASS_W-1:0] {
    CLS_BLACK, CLS_WHITE, CLS_RED, CLS_YELLOW,
    CLS_GREEN, CLS_CYAN, CLS_BLUE, CLS_MAGENTA
  } color_class_t;

  typedef enum logic [2:0] {
    S_IDLE, S_HSV, S_CLASS, S_READ, S_UPDATE, S_SCAN, S_EMIT
  } cwdc_state_t;

endpackage

>>> rtl/core/cwdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cwdc_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/center_window_dominant_color.sv
// Counts the colour classes of pixels in the centred WINDOW_SIZE square of each
// frame and, on the frame-end transfer, reports the most frequent class; a frame
// smaller than the window only clears the counts. A pixel in the window passes
// HSV, classify, count read and count write-back in the count RAM before the next
// pixel is taken. A frame end adds a sweep of the eight counts and any wait for
// the result register to be taken. Counts clear through per-entry valid flags.
module center_window_dominant_color
  import cwdc_pkg::*;
#(
  parameter int WINDOW_SIZE   = 256,
  parameter int MAX_DIMENSION = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       red_level,
  input  logic [7:0]       green_level,
  input  logic [7:0]       blue_level,
  input  logic             frame_end,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       dominant_color,
  input  logic             cfg_write,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int POS_W  = $clog2(MAX_DIMENSION);
  localparam int EFF_W  = POS_W + 1;
  localparam int WIDE_W = (EFF_W > CFG_W) ? EFF_W : CFG_W;
  localparam int SCAN_W = CLASS_W + 1;

  // Configuration
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective frame size and window bounds
  logic [WIDE_W-1:0] w_wide, h_wide;
  logic [EFF_W-1:0]  w_eff, h_eff, x0, y0, col_ext, row_ext;
  logic              big, in_window;
  logic [POS_W-1:0]  col, row;

  always_comb begin
    w_wide    = WIDE_W'(frame_width);
    h_wide    = WIDE_W'(frame_height);
    w_eff     = (w_wide > WIDE_W'(MAX_DIMENSION)) ? EFF_W'(MAX_DIMENSION) : EFF_W'(w_wide);
    h_eff     = (h_wide > WIDE_W'(MAX_DIMENSION)) ? EFF_W'(MAX_DIMENSION) : EFF_W'(h_wide);
    big       = (w_eff >= EFF_W'(WINDOW_SIZE)) && (h_eff >= EFF_W'(WINDOW_SIZE));
    x0        = (w_eff >> 1) - EFF_W'(WINDOW_SIZE / 2);
    y0        = (h_eff >> 1) - EFF_W'(WINDOW_SIZE / 2);
    col_ext   = EFF_W'(col);
    row_ext   = EFF_W'(row);
    in_window = big &&
                (col_ext >= x0) && (col_ext < x0 + EFF_W'(WINDOW_SIZE)) &&
                (row_ext >= y0) && (row_ext < y0 + EFF_W'(WINDOW_SIZE));
  end

  // Control
  cwdc_state_t state, state_next;
  logic        accept, load_pixel, clear_counts, ram_we, emit;
  logic        last_q;
  logic [SCAN_W-1:0] scan_idx;
  logic        cmp_valid;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    load_pixel   = 1'b0;
    clear_counts = 1'b0;
    ram_we       = 1'b0;
    emit         = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_window) begin
            load_pixel = 1'b1;
            state_next = S_HSV;
          end else if (frame_end && big) begin
            state_next = S_SCAN;
          end else if (frame_end) begin
            clear_counts = 1'b1;
          end
        end
      end
      S_HSV:   state_next = S_CLASS;
      S_CLASS: state_next = S_READ;
      S_READ:  state_next = S_UPDATE;
      S_UPDATE: begin
        ram_we     = 1'b1;
        state_next = last_q ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        if (scan_idx == SCAN_W'(NUM_CLASSES)) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          emit         = 1'b1;
          clear_counts = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Position tracking, advanced at every pixel transfer and reset by a frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (frame_end) begin
        col <= '0;
        row <= '0;
      end else if (col_ext + EFF_W'(1) >= w_eff) begin
        col <= '0;
        if (row < POS_W'(MAX_DIMENSION - 1)) begin
          row <= row + POS_W'(1);
        end
      end else begin
        col <= col + POS_W'(1);
      end
    end
  end

  // Pixel hold
  logic [LEVEL_W-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk) begin
    if (load_pixel) begin
      red_q   <= red_level;
      green_q <= green_level;
      blue_q  <= blue_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_q <= 1'b0;
    end else if (accept) begin
      last_q <= frame_end;
    end
  end

  // HSV step: value, chroma and hue numerator (hue = num / delta)
  logic [LEVEL_W-1:0] mx, mn, delta;
  logic signed [18:0] diff_s, num_raw, num_fix;
  logic [LEVEL_W-1:0] mx_q, delta_q;
  logic [16:0]        num_q;

  always_comb begin
    mx = red_q;
    if (green_q > mx) mx = green_q;
    if (blue_q > mx)  mx = blue_q;
    mn = red_q;
    if (green_q < mn) mn = green_q;
    if (blue_q < mn)  mn = blue_q;
    delta = mx - mn;
    if (mx == red_q) begin
      diff_s  = $signed({11'b0, green_q}) - $signed({11'b0, blue_q});
      num_raw = diff_s * 19'sd60;
    end else if (mx == green_q) begin
      diff_s  = $signed({11'b0, blue_q}) - $signed({11'b0, red_q});
      num_raw = diff_s * 19'sd60 + $signed({11'b0, delta}) * 19'sd120;
    end else begin
      diff_s  = $signed({11'b0, red_q}) - $signed({11'b0, green_q});
      num_raw = diff_s * 19'sd60 + $signed({11'b0, delta}) * 19'sd240;
    end
    num_fix = num_raw;
    if (num_raw < 0) begin
      num_fix = num_raw + $signed({11'b0, delta}) * 19'sd360;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_HSV) begin
      mx_q    <= mx;
      delta_q <= delta;
      num_q   <= num_fix[16:0];
    end
  end

  // Classify: hue >= k exactly when num >= k * delta
  logic [16:0]  d_ext, m_ext;
  logic         sat_high;
  color_class_t cls, cls_q;

  always_comb begin
    d_ext    = {9'b0, delta_q};
    m_ext    = {9'b0, mx_q};
    sat_high = (mx_q != '0) && (d_ext * SAT_SCALE >= m_ext * (SAT_LIMIT + 17'd1));
    if (sat_high) begin
      cls = CLS_RED;
    end else if (mx_q > VALUE_LIMIT) begin
      cls = CLS_WHITE;
    end else begin
      cls = CLS_BLACK;
    end
    if (delta_q != '0) begin
      if (num_q >= d_ext * HUE_YELLOW_LO && num_q < d_ext * HUE_GREEN_LO) begin
        cls = CLS_YELLOW;
      end else if (num_q >= d_ext * HUE_GREEN_LO && num_q < d_ext * HUE_CYAN_LO) begin
        cls = CLS_GREEN;
      end else if (num_q >= d_ext * HUE_CYAN_LO && num_q < d_ext * HUE_BLUE_LO) begin
        cls = CLS_CYAN;
      end else if (num_q >= d_ext * HUE_BLUE_LO && num_q < d_ext * HUE_MAGENTA_LO) begin
        cls = CLS_BLUE;
      end else if (num_q >= d_ext * HUE_MAGENTA_LO && num_q < d_ext * HUE_BAND_END) begin
        cls = CLS_MAGENTA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLASS) begin
      cls_q <= cls;
    end
  end

  // Count store
  logic [CLASS_W-1:0]     ram_raddr;
  logic [COUNT_W-1:0]     ram_rdata, ram_wdata, cur_count;
  logic [NUM_CLASSES-1:0] cnt_valid;

  assign ram_raddr = (state == S_SCAN) ? scan_idx[CLASS_W-1:0] : CLASS_W'(cls_q);
  assign cur_count = cnt_valid[cls_q] ? ram_rdata : '0;
  assign ram_wdata = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_W'(1);

  cwdc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_CLASSES)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (CLASS_W'(cls_q)),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || clear_counts) begin
      cnt_valid <= '0;
    end else if (ram_we) begin
      cnt_valid[cls_q] <= 1'b1;
    end
  end

  // Sweep the counts; a strict compare keeps the earlier class on a tie
  logic [CLASS_W-1:0] cmp_idx, best_idx;
  logic [COUNT_W-1:0] best_count, scan_count;

  assign scan_count = cnt_valid[cmp_idx] ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
    end else if (state == S_SCAN) begin
      if (scan_idx != SCAN_W'(NUM_CLASSES)) begin
        scan_idx <= scan_idx + SCAN_W'(1);
      end
      cmp_valid <= (scan_idx != SCAN_W'(NUM_CLASSES));
    end else begin
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      cmp_idx <= scan_idx[CLASS_W-1:0];
      if (cmp_valid && (cmp_idx == '0 || scan_count > best_count)) begin
        best_idx   <= cmp_idx;
        best_count <= scan_count;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dominant_color <= best_idx;
    end
  end

  a_update_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE |-> $past(state) == S_READ)
    else $error("count write-back without a preceding read");

  a_result_from_sweep: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EMIT)
    else $error("result raised outside the emit step");

  a_emit_after_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> $past(state) == S_SCAN || $past(state) == S_EMIT)
    else $error("emit entered without a count sweep");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ram_wdata != '0)
    else $error("count written back as zero");

endmodule
